// File: rtl/tls_pkg.sv
// text line sorter package: types, state codes, mode codes, default sizes
// no dependencies
package tls_pkg;
	localparam int MaxLinesDef = 64;
	localparam int LineBytesDef = 80;
	localparam logic [7:0] FirstMin = 8'd65;

	localparam logic [1:0] ModeByte = 2'd0;
	localparam logic [1:0] ModeEol = 2'd1;
	localparam logic [1:0] ModeFetch = 2'd2;

	typedef enum logic [3:0] {
		ST_LOAD, ST_INIT, ST_OI, ST_OJ, ST_CMP_RD, ST_CMP_WAIT, ST_CMP, ST_SWAP,
		ST_READ, ST_FETCH_WAIT, ST_FETCH, ST_DONE
	} state_t;
endpackage

// File: rtl/tls_mem.sv
// simple synchronous ram: one write port, one registered read port
// depends on nothing
module tls_mem #(
	parameter int Width = 8,
	parameter int Depth = 64
) (
	input  logic                     clk,
	input  logic                     we,
	input  logic [$clog2(Depth)-1:0] waddr,
	input  logic [Width-1:0]         wdata,
	input  logic [$clog2(Depth)-1:0] raddr,
	output logic [Width-1:0]         rdata
);
	logic [Width-1:0] mem [Depth];
	always_ff @(posedge clk) begin
		if (we) mem[waddr] <= wdata;
		rdata <= mem[raddr];
	end
endmodule

// File: rtl/text_line_sorter_top.sv
// text line sorter top: load, exchange sort over an order table, read back
// depends on tls_pkg and tls_mem
//
// channel | signals                                   | dir
// command | start, busy, mode, char_byte              | in
// result  | strobe, out_byte, line_end, text_end,     | out
//         | no_data, overflow                         |
//
// load items and no-data fetches leave busy low. the end item that stops loading
// starts the sort, busy meanwhile: the order table is filled, then each pair is
// compared byte by byte over the shared prefix, then by length; a swap writes twice.
// fetch items read the order table, then the line store, busy meanwhile.
// a result is strobed for one cycle and the receiver cannot stall it.
// reset clears control only; stores are written before they are read.
module text_line_sorter_top
	import tls_pkg::*;
#(
	parameter int MaxLines = MaxLinesDef,
	parameter int LineBytes = LineBytesDef
) (
	input  logic       clk,
	input  logic       arst_n,
	input  logic       start,
	output logic       busy,
	input  logic [1:0] mode,
	input  logic [7:0] char_byte,
	output logic       strobe,
	output logic [7:0] out_byte,
	output logic       line_end,
	output logic       text_end,
	output logic       no_data,
	output logic       overflow
);
	localparam int LW = $clog2(MaxLines);
	localparam int CW = $clog2(MaxLines + 1);
	localparam int PW = $clog2(LineBytes + 1);
	localparam int SD = MaxLines * LineBytes;
	localparam int SW = $clog2(SD);

	state_t state_q, state_d;
	logic [CW-1:0] total_q;
	logic [PW-1:0] cur_q;
	logic [7:0] first_q;
	logic drop_q;
	logic [CW-1:0] i_q, j_q;   // sort indices, also init counter / read_line
	logic [PW-1:0] pos_q;
	logic [LW-1:0] a_q, b_q;   // line ids at order[i], order[j]
	logic [PW-1:0] la_q;
	logic [7:0] x_q;
	logic phase_b_q;           // compare: 0 reading line a byte, 1 line b
	logic [CW-1:0] next_i, next_j;

	// memories
	logic s_we; logic [SW-1:0] s_wa, s_ra; logic [7:0] s_wd, s_rd;
	logic l_we; logic [LW-1:0] l_wa, l_ra; logic [PW-1:0] l_wd, l_rd;
	logic o_we; logic [LW-1:0] o_wa, o_ra; logic [LW-1:0] o_wd, o_rd;

	tls_mem #(.Width(8), .Depth(SD)) u_store (.clk, .we(s_we), .waddr(s_wa),
		.wdata(s_wd), .raddr(s_ra), .rdata(s_rd));
	tls_mem #(.Width(PW), .Depth(MaxLines)) u_len (.clk, .we(l_we), .waddr(l_wa),
		.wdata(l_wd), .raddr(l_ra), .rdata(l_rd));
	tls_mem #(.Width(LW), .Depth(MaxLines)) u_ord (.clk, .we(o_we), .waddr(o_wa),
		.wdata(o_wd), .raddr(o_ra), .rdata(o_rd));

	function automatic logic [SW-1:0] saddr(logic [LW-1:0] l, logic [PW-1:0] p);
		logic [SW+PW-1:0] t;
		t = (SW+PW)'(l) * (SW+PW)'(LineBytes) + (SW+PW)'(p);
		return t[SW-1:0];
	endfunction

	logic acc;
	assign acc = start && !busy;
	assign busy = !(state_q == ST_LOAD || state_q == ST_READ || state_q == ST_DONE);

	// during a compare l_rd holds the length of line b
	logic [PW-1:0] minl;
	assign minl = (la_q < l_rd) ? la_q : l_rd;
	logic swap_c;
	logic [CW-1:0] tot_m1;
	assign tot_m1 = total_q - CW'(1);
	assign next_i = i_q + CW'(1);
	assign next_j = j_q + CW'(1);

	logic [PW-1:0] flen;
	assign flen = l_rd;

	logic res_v, res_le, res_te, res_nd;
	logic [7:0] res_b;

	always_comb begin
		state_d = state_q;
		s_we = 1'b0; s_wa = saddr(total_q[LW-1:0], cur_q); s_wd = char_byte;
		s_ra = saddr(a_q, pos_q);
		l_we = 1'b0; l_wa = total_q[LW-1:0]; l_wd = cur_q; l_ra = a_q;
		o_we = 1'b0; o_wa = i_q[LW-1:0]; o_wd = i_q[LW-1:0]; o_ra = i_q[LW-1:0];
		swap_c = 1'b0;
		res_v = 1'b0; res_b = '0; res_le = 1'b0; res_te = 1'b0; res_nd = 1'b0;
		case (state_q)
			ST_LOAD: begin
				if (acc && mode == ModeByte && cur_q < PW'(LineBytes) && total_q < CW'(MaxLines))
					s_we = 1'b1;
				if (acc && mode == ModeEol) begin
					if (cur_q == '0 || first_q < FirstMin) state_d = ST_INIT;
					else if (total_q < CW'(MaxLines)) l_we = 1'b1;
				end
				if (acc && mode == ModeFetch) begin
					res_v = 1'b1; res_nd = 1'b1;
				end
			end
			ST_INIT: begin
				if (i_q >= total_q) state_d = ST_OI;
				else o_we = 1'b1;
			end
			ST_OI: begin
				o_ra = i_q[LW-1:0];
				if (total_q < CW'(2) || i_q >= tot_m1) state_d = ST_READ;
				else state_d = ST_OJ;
			end
			ST_OJ: begin
				o_ra = next_j[LW-1:0];
				state_d = ST_CMP_RD;
			end
			ST_CMP_RD: begin
				// order[j] arriving; read length of line a
				l_ra = a_q;
				state_d = ST_CMP_WAIT;
			end
			ST_CMP_WAIT: begin
				l_ra = b_q;
				s_ra = saddr(a_q, pos_q);
				state_d = ST_CMP;
			end
			ST_CMP: begin
				// byte of line a (i) at pos then line b (j) alternates
				l_ra = b_q;
				s_ra = phase_b_q ? saddr(a_q, pos_q + PW'(1)) : saddr(b_q, pos_q);
				if (!phase_b_q && pos_q >= minl) begin
					swap_c = l_rd < la_q;
					state_d = swap_c ? ST_SWAP : ST_OJ;
				end else if (phase_b_q && s_rd != x_q) begin
					swap_c = s_rd < x_q;
					state_d = swap_c ? ST_SWAP : ST_OJ;
				end
				if (state_d == ST_OJ && next_j >= total_q) state_d = ST_OI;
			end
			ST_SWAP: begin
				// two writes: order[j] first, then order[i]
				o_we = 1'b1;
				if (!phase_b_q) begin
					o_wa = j_q[LW-1:0]; o_wd = a_q;
				end else begin
					o_wa = i_q[LW-1:0]; o_wd = b_q;
					state_d = (next_j >= total_q) ? ST_OI : ST_OJ;
				end
			end
			ST_READ: begin
				o_ra = i_q[LW-1:0];
				if (acc && mode == ModeFetch) begin
					if (total_q != '0 && i_q < total_q) begin
						state_d = ST_FETCH_WAIT;
					end else begin
						state_d = ST_DONE;
						res_v = 1'b1; res_nd = 1'b1;
					end
				end
			end
			ST_FETCH_WAIT: begin
				l_ra = o_rd; s_ra = saddr(o_rd, pos_q);
				state_d = ST_FETCH;
			end
			ST_FETCH: begin
				res_v = 1'b1;
				state_d = ST_READ;
				if (pos_q < flen && pos_q < PW'(LineBytes)) begin
					res_b = s_rd;
				end else begin
					res_le = 1'b1;
					res_te = (next_i >= total_q);
					if (res_te) state_d = ST_DONE;
				end
			end
			ST_DONE: begin
				if (acc && mode == ModeFetch) begin
					res_v = 1'b1; res_nd = 1'b1;
				end
			end
			default: state_d = ST_LOAD;
		endcase
	end

	always_ff @(posedge clk or negedge arst_n) begin
		if (!arst_n) begin
			state_q <= ST_LOAD; total_q <= '0; cur_q <= '0; first_q <= '0; drop_q <= 1'b0;
			i_q <= '0; j_q <= '0; pos_q <= '0; phase_b_q <= 1'b0;
			a_q <= '0; b_q <= '0; la_q <= '0; x_q <= '0;
			strobe <= 1'b0; out_byte <= '0; line_end <= 1'b0; text_end <= 1'b0;
			no_data <= 1'b0; overflow <= 1'b0;
		end else begin
			state_q <= state_d;
			strobe <= res_v;
			if (res_v) begin
				out_byte <= res_b; line_end <= res_le; text_end <= res_te;
				no_data <= res_nd; overflow <= drop_q;
			end
			case (state_q)
				ST_LOAD: if (acc) begin
					if (mode == ModeByte) begin
						if (cur_q == '0) first_q <= char_byte;
						if (cur_q < PW'(LineBytes)) cur_q <= cur_q + PW'(1);
						else drop_q <= 1'b1;
					end else if (mode == ModeEol) begin
						if (!(cur_q == '0 || first_q < FirstMin)) begin
							if (total_q < CW'(MaxLines)) total_q <= total_q + CW'(1);
							else drop_q <= 1'b1;
						end
						cur_q <= '0; first_q <= '0; i_q <= '0;
					end
				end
				ST_INIT: if (i_q < total_q) i_q <= next_i; else i_q <= '0;
				ST_OI: begin
					j_q <= i_q;
					if (state_d == ST_READ) i_q <= '0;
				end
				ST_OJ: begin
					// first pair of a row: the order table returns order[i]
					j_q <= next_j;
					if (j_q == i_q) a_q <= o_rd;
				end
				ST_CMP_RD: begin
					b_q <= o_rd;
					pos_q <= '0; phase_b_q <= 1'b0;
				end
				ST_CMP_WAIT: la_q <= l_rd;
				ST_CMP: begin
					if (state_d != ST_CMP) begin
						pos_q <= '0; phase_b_q <= 1'b0;
						if (state_d == ST_OI) i_q <= next_i;
					end else if (!phase_b_q) begin
						x_q <= s_rd; phase_b_q <= 1'b1;
					end else begin
						phase_b_q <= 1'b0; pos_q <= pos_q + PW'(1);
					end
				end
				ST_SWAP: begin
					if (!phase_b_q) begin
						phase_b_q <= 1'b1;
					end else begin
						phase_b_q <= 1'b0; a_q <= b_q;
						if (state_d == ST_OI) i_q <= next_i;
					end
				end
				ST_FETCH: begin
					if (!res_le) begin
						pos_q <= pos_q + PW'(1);
					end else begin
						pos_q <= '0; i_q <= next_i;
					end
				end
				default: ;
			endcase
		end
	end
endmodule

// File: test/testbench.sv
// testbench for text_line_sorter_top: loads lines, lets the sort run, reads the text back
// depends on tls_pkg and the rtl of text_line_sorter_top; predicts every result in a class
module testbench;
	import tls_pkg::*;
	timeunit 1ns;
	timeprecision 1ps;

	localparam logic [1:0] ModeSpare = 2'd3;
	localparam int LinesWanted = 68;

	typedef enum logic [1:0] {PH_LOADING, PH_READING, PH_FINISHED} sort_phase_t;

	typedef struct {
		logic [7:0] ob;
		logic       le;
		logic       te;
		logic       nd;
		logic       ov;
	} text_result_t;

	class sorter_board;
		logic [7:0]   line_text [MaxLinesDef][LineBytesDef];
		int           line_len [MaxLinesDef];
		int           order [MaxLinesDef];
		int           stored, cur_len, rd_line, rd_pos;
		logic [7:0]   first_ch;
		sort_phase_t  phase;
		bit           dropped;
		text_result_t results_due [$];
		int           mismatches;

		function new();
			stored = 0;
			cur_len = 0;
			rd_line = 0;
			rd_pos = 0;
			first_ch = 8'd0;
			phase = PH_LOADING;
			dropped = 1'b0;
			mismatches = 0;
		endfunction

		function bit sorts_first(int a, int b);
			int n;
			n = line_len[a] < line_len[b] ? line_len[a] : line_len[b];
			for (int i = 0; i < n; i++)
				if (line_text[a][i] != line_text[b][i])
					return line_text[a][i] < line_text[b][i];
			return line_len[a] < line_len[b];
		endfunction

		function void sort_text();
			int t;
			for (int i = 0; i < stored; i++)
				order[i] = i;
			for (int i = 0; i + 1 < stored; i++)
				for (int j = i + 1; j < stored; j++)
					if (sorts_first(order[j], order[i])) begin
						t = order[i];
						order[i] = order[j];
						order[j] = t;
					end
		endfunction

		function void note(logic [1:0] m, logic [7:0] b);
			text_result_t r;
			int idx;
			if (m == ModeByte) begin
				if (phase != PH_LOADING)
					return;
				if (cur_len == 0)
					first_ch = b;
				if (cur_len < LineBytesDef) begin
					if (stored < MaxLinesDef)
						line_text[stored][cur_len] = b;
					cur_len++;
				end else begin
					dropped = 1'b1;
				end
			end else if (m == ModeEol) begin
				if (phase != PH_LOADING)
					return;
				if (cur_len == 0 || first_ch < FirstMin) begin
					sort_text();
					phase = PH_READING;
					rd_line = 0;
					rd_pos = 0;
				end else if (stored < MaxLinesDef) begin
					line_len[stored] = cur_len;
					stored++;
				end else begin
					dropped = 1'b1;
				end
				cur_len = 0;
				first_ch = 8'd0;
			end else if (m == ModeFetch) begin
				r = '{8'd0, 1'b0, 1'b0, 1'b0, dropped};
				if (phase != PH_READING || stored == 0 || rd_line >= stored) begin
					r.nd = 1'b1;
					if (phase == PH_READING)
						phase = PH_FINISHED;
				end else begin
					idx = order[rd_line];
					if (rd_pos < line_len[idx]) begin
						r.ob = line_text[idx][rd_pos];
						rd_pos++;
					end else begin
						r.le = 1'b1;
						rd_pos = 0;
						rd_line++;
						if (rd_line >= stored) begin
							r.te = 1'b1;
							phase = PH_FINISHED;
						end
					end
				end
				results_due.push_back(r);
			end
		endfunction

		function void check(text_result_t got);
			text_result_t want;
			if (results_due.size() == 0) begin
				mismatches++;
				if (mismatches <= 10)
					$display("unexpected result: byte %h le %b te %b nd %b ov %b",
						got.ob, got.le, got.te, got.nd, got.ov);
				return;
			end
			want = results_due.pop_front();
			if (got.ob !== want.ob || got.le !== want.le || got.te !== want.te ||
					got.nd !== want.nd || got.ov !== want.ov) begin
				mismatches++;
				if (mismatches <= 10)
					$display("mismatch: want %h/%b/%b/%b/%b got %h/%b/%b/%b/%b",
						want.ob, want.le, want.te, want.nd, want.ov,
						got.ob, got.le, got.te, got.nd, got.ov);
			end
		endfunction
	endclass

	logic       clk;
	logic       arst_n;
	logic       start;
	logic       busy;
	logic [1:0] mode;
	logic [7:0] char_byte;
	logic       strobe;
	logic [7:0] out_byte;
	logic       line_end;
	logic       text_end;
	logic       no_data;
	logic       overflow;

	sorter_board board;
	int          items_sent;
	logic [7:0]  line_buf [90];
	logic [7:0]  kept_text [LinesWanted][90];
	int          kept_len [LinesWanted];
	int          kept;

	text_line_sorter_top dut (
		.clk(clk), .arst_n(arst_n), .start(start), .busy(busy), .mode(mode),
		.char_byte(char_byte), .strobe(strobe), .out_byte(out_byte),
		.line_end(line_end), .text_end(text_end), .no_data(no_data),
		.overflow(overflow)
	);

	always #6 clk = ~clk;

	always @(posedge clk) begin
		if (arst_n && strobe)
			board.check('{out_byte, line_end, text_end, no_data, overflow});
	end

	task automatic send_item(logic [1:0] m, logic [7:0] b);
		// random idle gaps, but none in the middle of the run
		while ((items_sent < 300 || items_sent > 650) && $urandom_range(0, 99) < 11) begin
			start <= 1'b0;
			@(posedge clk);
		end
		start <= 1'b1;
		mode <= m;
		char_byte <= b;
		do @(posedge clk); while (busy);
		board.note(m, b);
		items_sent++;
	endtask

	task automatic wait_drained();
		start <= 1'b0;
		while (board.results_due.size() != 0)
			@(posedge clk);
		repeat (4) @(posedge clk);
	endtask

	// sends line_buf[0..n-1] and the end item, keeps a copy for prefix reuse
	task automatic send_line(int n);
		for (int i = 0; i < n; i++) begin
			send_item(ModeByte, line_buf[i]);
			if ($urandom_range(0, 99) < 3)
				send_item(ModeFetch, 8'($urandom));
			if ($urandom_range(0, 99) < 2)
				send_item(ModeSpare, 8'($urandom));
		end
		send_item(ModeEol, 8'($urandom));
		if (kept < LinesWanted && n > 0) begin
			for (int i = 0; i < n && i < 90; i++)
				kept_text[kept][i] = line_buf[i];
			kept_len[kept] = n;
			kept++;
		end
	endtask

	task automatic send_text(string s);
		for (int i = 0; i < s.len(); i++)
			line_buf[i] = s[i];
		send_line(s.len());
	endtask

	initial begin
		#10_000_000;
		$display("FAIL text_line_sorter_top");
		$finish;
	end

	initial begin
		int n, k, p;
		board = new();
		clk = 1'b0;
		arst_n = 1'b0;
		start = 1'b0;
		mode = ModeByte;
		char_byte = 8'd0;
		items_sent = 0;
		kept = 0;
		repeat (7) @(posedge clk);
		arst_n <= 1'b1;
		@(posedge clk);

		// fetch during loading and the spare mode
		send_item(ModeFetch, 8'hff);
		send_item(ModeSpare, 8'h00);
		wait_drained();
		send_text("ABC");
		send_text("AB");
		send_text("ABD");
		send_text("A");
		// zero byte kept as text, top byte value first
		line_buf[0] = 8'hff; line_buf[1] = 8'h00; line_buf[2] = 8'h7f;
		send_line(3);
		line_buf[0] = 8'h41; line_buf[1] = 8'h42; line_buf[2] = 8'h00;
		send_line(3);
		// long line: bytes past the line size are dropped
		for (int i = 0; i < 85; i++)
			line_buf[i] = 8'($urandom_range(65, 255));
		send_line(85);

		// random lines, enough to overrun the line capacity
		while (kept < LinesWanted) begin
			if (kept > 0 && $urandom_range(0, 3) == 0) begin
				k = $urandom_range(0, kept - 1);
				p = $urandom_range(1, kept_len[k] > 80 ? 80 : kept_len[k]);
				n = p + $urandom_range(0, 6);
				for (int i = 0; i < p; i++)
					line_buf[i] = kept_text[k][i];
				for (int i = p; i < n; i++)
					line_buf[i] = 8'($urandom);
			end else begin
				n = $urandom_range(0, 19) == 0 ? $urandom_range(70, 88)
					: $urandom_range(1, 6);
				line_buf[0] = 8'($urandom_range(65, 255));
				for (int i = 1; i < n; i++)
					line_buf[i] = 8'($urandom);
			end
			send_line(n);
		end

		// the stopping line: empty, or first byte below the threshold
		if ($urandom_range(0, 1) == 0) begin
			send_item(ModeEol, 8'($urandom));
		end else begin
			line_buf[0] = $urandom_range(0, 1) ? 8'd64 : 8'($urandom_range(0, 64));
			n = $urandom_range(1, 5);
			for (int i = 1; i < n; i++)
				line_buf[i] = 8'($urandom);
			send_line(n);
		end
		// loads after the stop are ignored
		send_item(ModeByte, 8'h5a);
		send_item(ModeEol, 8'h00);
		send_item(ModeSpare, 8'h11);
		wait_drained();

		while (board.phase != PH_FINISHED)
			send_item(ModeFetch, 8'($urandom));
		for (int i = 0; i < 8; i++)
			send_item($urandom_range(0, 1) ? ModeFetch : ModeByte, 8'($urandom));
		start <= 1'b0;

		while (board.results_due.size() != 0)
			@(posedge clk);
		repeat (20) @(posedge clk);
		if (board.mismatches == 0 && board.results_due.size() == 0)
			$display("PASS text_line_sorter_top");
		else
			$display("FAIL text_line_sorter_top");
		$finish;
	end
endmodule
